// ----- src/lob_pkg.sv -----
// ----------------------------------------------------------------------------
// lob_pkg
// Shared types and codes of the limit order book.
// ----------------------------------------------------------------------------
package lob_pkg;

  localparam int ENTRY_W = 96;

  // request modes
  localparam logic [2:0] MODE_ADD_BID = 3'd0;
  localparam logic [2:0] MODE_ADD_ASK = 3'd1;
  localparam logic [2:0] MODE_CAN_BID = 3'd2;
  localparam logic [2:0] MODE_CAN_ASK = 3'd3;
  localparam logic [2:0] MODE_MKT_BUY = 3'd4;
  localparam logic [2:0] MODE_MKT_SELL = 3'd5;

  // result status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FILLED    = 3'd4;
  localparam logic [2:0] ST_MKT_DONE  = 3'd5;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] agent;
    logic [15:0] qty;
    logic [15:0] price;
  } entry_t;

endpackage

// ----- src/limit_order_book.sv -----
// ----------------------------------------------------------------------------
// limit_order_book
// Bid and ask books with price-time priority, add / cancel / market requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel, one word per request, the mode in
//   s_tuser; s_tready is high only while no request is in progress. Results
//   leave on the m_ channel with the status in m_tuser, m_tlast marks the
//   final result of a request. Adds and cancels give one result, a market
//   order one result per fully filled resting order plus a closing result.
//   Each book is a circular buffer in its own RAM (one read, one write port,
//   registered read), best entry at the head pointer. An add moves the
//   entries behind the new one back by one slot; a cancel scans from the
//   head to the order and moves the entries behind it forward; a market
//   order removes fully filled orders at the head and reduces a partly
//   filled one in place.
//   A result waiting in the output register does not block the next request;
//   the sequencer holds only when it has a new result and the register is
//   still occupied (m_tvalid high, m_tready low).
//   Reset (rst, synchronous) empties both books, clears the last-filled
//   prices and drops any pending result. No RAM clearing pass is needed.
// ----------------------------------------------------------------------------
module limit_order_book #(
  parameter int BOOK_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // price[15:0], quantity[31:16], agent_id[63:32], order_id[95:64]
  input  logic [95:0]  s_tdata,
  // mode[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // agent_id_res[31:0], order_id_res[63:32], units[79:64],
  // best_bid[95:80], best_ask[111:96]
  output logic [111:0] m_tdata,
  // status[2:0]
  output logic [2:0]   m_tuser,
  output logic         m_tlast
);

  localparam int IDX_W = $clog2(BOOK_DEPTH);
  localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_RD, S_ADD_WR, S_CAN_RD, S_CAN_CHK, S_SH_RD, S_SH_WR,
    S_M_CHK, S_M_DAT, S_M_HPD, S_EMIT
  } state_t;

  state_t st;

  logic             side;
  lob_pkg::entry_t  req;
  lob_pkg::entry_t  ent;
  logic [CNT_W-1:0] k;
  logic [15:0]      left;

  logic [CNT_W-1:0] cnt   [2];
  logic [IDX_W-1:0] head  [2];
  logic [15:0]      hprice[2];
  logic [15:0]      lastf [2];

  logic [2:0]  e_status;
  logic [31:0] e_agent;
  logic [31:0] e_id;
  logic [15:0] e_units;
  logic        e_last;

  logic            we;
  logic [IDX_W-1:0] waddr;
  lob_pkg::entry_t wdata;
  logic [IDX_W-1:0] raddr;
  logic [lob_pkg::ENTRY_W-1:0] bid_rd, ask_rd;
  lob_pkg::entry_t rd;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] l);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(h) + (CNT_W + 1)'(l);
    if (s >= (CNT_W + 1)'(BOOK_DEPTH)) begin
      s = s - (CNT_W + 1)'(BOOK_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  logic worse;
  logic slot_free;
  logic emit_go;
  logic [15:0] best_bid, best_ask;

  assign rd        = lob_pkg::entry_t'(side ? ask_rd : bid_rd);
  assign worse     = side ? (rd.price > req.price) : (rd.price < req.price);
  assign slot_free = !m_tvalid || m_tready;
  assign emit_go   = (st == S_EMIT) && slot_free;
  assign s_tready  = (st == S_IDLE);
  assign best_bid  = (cnt[0] != '0) ? hprice[0] : lastf[0];
  assign best_ask  = (cnt[1] != '0) ? hprice[1] : lastf[1];

  // RAM address and write selection
  always_comb begin
    we    = 1'b0;
    waddr = phys(head[side], '0);
    wdata = req;
    raddr = phys(head[side], '0);
    case (st)
      S_ADD_RD: begin
        if (k == '0) begin
          we = 1'b1;
        end else begin
          raddr = phys(head[side], CNT_W'(k - 1'b1));
        end
      end
      S_ADD_WR: begin
        we    = 1'b1;
        waddr = phys(head[side], k);
        wdata = worse ? rd : req;
      end
      S_CAN_RD: raddr = phys(head[side], k);
      S_SH_RD:  raddr = phys(head[side], k);
      S_SH_WR: begin
        we    = 1'b1;
        waddr = phys(head[side], CNT_W'(k - 1'b1));
        wdata = rd;
      end
      S_M_DAT: begin
        raddr = phys(head[side], CNT_W'(1));
        if (rd.qty > left) begin
          we        = 1'b1;
          wdata     = rd;
          wdata.qty = rd.qty - left;
        end
      end
      default: ;
    endcase
  end

  lob_ram #(.WIDTH(lob_pkg::ENTRY_W), .DEPTH(BOOK_DEPTH)) u_bid_ram (
    .clk(clk), .we(we && !side), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(bid_rd)
  );

  lob_ram #(.WIDTH(lob_pkg::ENTRY_W), .DEPTH(BOOK_DEPTH)) u_ask_ram (
    .clk(clk), .we(we && side), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(ask_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      cnt[0]   <= '0;
      cnt[1]   <= '0;
      head[0]  <= '0;
      head[1]  <= '0;
      lastf[0] <= '0;
      lastf[1] <= '0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= emit_go || (m_tvalid && !m_tready);
      case (st)
        S_IDLE: begin
          if (s_tvalid) begin
            req.price <= s_tdata[15:0];
            req.qty   <= s_tdata[31:16];
            req.agent <= s_tdata[63:32];
            req.id    <= s_tdata[95:64];
            left      <= s_tdata[31:16];
            side      <= (s_tuser == lob_pkg::MODE_ADD_ASK) ||
                         (s_tuser == lob_pkg::MODE_CAN_ASK) ||
                         (s_tuser == lob_pkg::MODE_MKT_BUY);
            k         <= '0;
            case (s_tuser)
              lob_pkg::MODE_ADD_BID: st <= S_ADD_RD;
              lob_pkg::MODE_ADD_ASK: st <= S_ADD_RD;
              lob_pkg::MODE_CAN_BID: st <= S_CAN_RD;
              lob_pkg::MODE_CAN_ASK: st <= S_CAN_RD;
              lob_pkg::MODE_MKT_BUY: st <= S_M_CHK;
              lob_pkg::MODE_MKT_SELL: st <= S_M_CHK;
              default: st <= S_IDLE;
            endcase
            if (s_tuser == lob_pkg::MODE_ADD_BID) begin
              k <= cnt[0];
            end else if (s_tuser == lob_pkg::MODE_ADD_ASK) begin
              k <= cnt[1];
            end
          end
        end
        S_ADD_RD: begin
          e_agent <= req.agent;
          e_id    <= req.id;
          e_units <= req.qty;
          e_last  <= 1'b1;
          if (cnt[side] == CNT_W'(BOOK_DEPTH)) begin
            e_status <= lob_pkg::ST_FULL;
            st       <= S_EMIT;
          end else if (k == '0) begin
            hprice[side] <= req.price;
            cnt[side]    <= cnt[side] + 1'b1;
            e_status     <= lob_pkg::ST_ADDED;
            st           <= S_EMIT;
          end else begin
            st <= S_ADD_WR;
          end
        end
        S_ADD_WR: begin
          if (worse) begin
            k  <= k - 1'b1;
            st <= S_ADD_RD;
          end else begin
            cnt[side] <= cnt[side] + 1'b1;
            e_status  <= lob_pkg::ST_ADDED;
            st        <= S_EMIT;
          end
        end
        S_CAN_RD: begin
          if (k == cnt[side]) begin
            e_status <= lob_pkg::ST_NOT_FOUND;
            e_agent  <= '0;
            e_id     <= req.id;
            e_units  <= '0;
            e_last   <= 1'b1;
            st       <= S_EMIT;
          end else begin
            st <= S_CAN_CHK;
          end
        end
        S_CAN_CHK: begin
          k <= k + 1'b1;
          if (rd.id == req.id) begin
            ent <= rd;
            st  <= S_SH_RD;
          end else begin
            st <= S_CAN_RD;
          end
        end
        S_SH_RD: begin
          if (k == cnt[side]) begin
            cnt[side] <= cnt[side] - 1'b1;
            e_status  <= lob_pkg::ST_CANCELLED;
            e_agent   <= ent.agent;
            e_id      <= ent.id;
            e_units   <= ent.qty;
            e_last    <= 1'b1;
            st        <= S_EMIT;
          end else begin
            st <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          // entry shifted into the best slot becomes the new best price
          if (k == CNT_W'(1)) begin
            hprice[side] <= rd.price;
          end
          k  <= k + 1'b1;
          st <= S_SH_RD;
        end
        S_M_CHK: begin
          if (left == '0 || cnt[side] == '0) begin
            e_status <= lob_pkg::ST_MKT_DONE;
            e_agent  <= '0;
            e_id     <= '0;
            e_units  <= left;
            e_last   <= 1'b1;
            st       <= S_EMIT;
          end else begin
            st <= S_M_DAT;
          end
        end
        S_M_DAT: begin
          if (rd.qty <= left) begin
            left        <= left - rd.qty;
            lastf[side] <= rd.price;
            cnt[side]   <= cnt[side] - 1'b1;
            head[side]  <= (head[side] == IDX_W'(BOOK_DEPTH - 1)) ? '0
                           : head[side] + 1'b1;
            e_status    <= lob_pkg::ST_FILLED;
            e_agent     <= rd.agent;
            e_id        <= rd.id;
            e_units     <= rd.qty;
            e_last      <= 1'b0;
            st          <= S_M_HPD;
          end else begin
            e_status <= lob_pkg::ST_MKT_DONE;
            e_agent  <= '0;
            e_id     <= '0;
            e_units  <= '0;
            e_last   <= 1'b1;
            left     <= '0;
            st       <= S_EMIT;
          end
        end
        S_M_HPD: begin
          // read of the new head was issued while the old one was removed
          hprice[side] <= rd.price;
          st           <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            m_tuser          <= e_status;
            m_tdata[31:0]    <= e_agent;
            m_tdata[63:32]   <= e_id;
            m_tdata[79:64]   <= e_units;
            m_tdata[95:80]   <= best_bid;
            m_tdata[111:96]  <= best_ask;
            m_tlast          <= e_last;
            st               <= e_last ? S_IDLE : S_M_CHK;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/lob_ram.sv -----
// ----------------------------------------------------------------------------
// lob_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lob_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/lob_checker.sv -----
// ----------------------------------------------------------------------------
// lob_checker
// Port-level checks of the limit order book result stream.
// ----------------------------------------------------------------------------
module lob_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata,
  input logic [2:0]   m_tuser,
  input logic         m_tlast
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
      $stable(m_tlast))
    else $error("result word changed while stalled");

  // a filled resting order never closes a request
  a_fill_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == lob_pkg::ST_FILLED |-> !m_tlast)
    else $error("fill result marked last");

  // every other status is a closing word
  a_other_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != lob_pkg::ST_FILLED |-> m_tlast)
    else $error("closing result without tlast");

  // market close carries no agent or order id
  a_done_ids: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == lob_pkg::ST_MKT_DONE |->
      m_tdata[63:0] == 64'd0)
    else $error("market close with nonzero ids");

  // reset drops any pending result
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind limit_order_book lob_checker u_lob_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

// ----- dv/limit_order_book_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_test
// Self-checking bench: directed table plus random add, cancel and market
// requests, every result word compared with a behavioral book model.
// ----------------------------------------------------------------------------
module limit_order_book_test;

  localparam int DEPTH = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] agent;
    logic [31:0] oid;
    logic [15:0] units;
    logic [15:0] bid;
    logic [15:0] ask;
    logic        last;
  } fill_t;

  typedef struct {
    logic [2:0]  mode;
    logic [15:0] price;
    logic [15:0] qty;
    logic [31:0] agent;
    logic [31:0] oid;
    bit          typed;   // expected status/units written in the row
    logic [2:0]  exp_status;
    logic [15:0] exp_units;
  } order_row_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [111:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;

  limit_order_book #(.BOOK_DEPTH(DEPTH)) uut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // book model: side 0 holds bids, side 1 holds asks, best first
  lob_pkg::entry_t book [2][DEPTH];
  int          book_cnt [2];
  logic [15:0] last_fill [2];
  fill_t       fills_due [$];
  int          errors = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          quiet_cycles = 0;

  function automatic logic [15:0] top_price(int side);
    return book_cnt[side] != 0 ? book[side][0].price : last_fill[side];
  endfunction

  function automatic void post_fill(logic [2:0] st, logic [31:0] ag, logic [31:0] id,
                                    logic [15:0] un, logic lst);
    fill_t f;
    f.status = st; f.agent = ag; f.oid = id; f.units = un;
    f.bid = top_price(0); f.ask = top_price(1); f.last = lst;
    fills_due = {fills_due, f};
  endfunction

  function automatic void drop_entry(int side, int pos);
    for (int i = pos; i < book_cnt[side] - 1; i++) book[side][i] = book[side][i + 1];
    book_cnt[side]--;
  endfunction

  function automatic void book_request(logic [2:0] mode, logic [15:0] price,
                                       logic [15:0] qty, logic [31:0] ag, logic [31:0] id);
    int side;
    int pos;
    logic [15:0] left;
    lob_pkg::entry_t e;
    side = (mode == lob_pkg::MODE_ADD_BID || mode == lob_pkg::MODE_CAN_BID ||
            mode == lob_pkg::MODE_MKT_SELL) ? 0 : 1;
    case (mode)
      lob_pkg::MODE_ADD_BID, lob_pkg::MODE_ADD_ASK: begin
        if (book_cnt[side] >= DEPTH) begin
          post_fill(lob_pkg::ST_FULL, ag, id, qty, 1'b1);
        end else begin
          pos = 0;
          while (pos < book_cnt[side] &&
                 !(side == 0 ? book[side][pos].price < price : book[side][pos].price > price))
            pos++;
          for (int i = book_cnt[side]; i > pos; i--) book[side][i] = book[side][i - 1];
          e.price = price; e.qty = qty; e.agent = ag; e.id = id;
          book[side][pos] = e;
          book_cnt[side]++;
          post_fill(lob_pkg::ST_ADDED, ag, id, qty, 1'b1);
        end
      end
      lob_pkg::MODE_CAN_BID, lob_pkg::MODE_CAN_ASK: begin
        pos = 0;
        while (pos < book_cnt[side] && book[side][pos].id != id) pos++;
        if (pos < book_cnt[side]) begin
          e = book[side][pos];
          drop_entry(side, pos);
          post_fill(lob_pkg::ST_CANCELLED, e.agent, e.id, e.qty, 1'b1);
        end else begin
          post_fill(lob_pkg::ST_NOT_FOUND, '0, id, '0, 1'b1);
        end
      end
      lob_pkg::MODE_MKT_BUY, lob_pkg::MODE_MKT_SELL: begin
        left = qty;
        while (left != 0 && book_cnt[side] != 0) begin
          e = book[side][0];
          if (e.qty <= left) begin
            left -= e.qty;
            last_fill[side] = e.price;
            drop_entry(side, 0);
            post_fill(lob_pkg::ST_FILLED, e.agent, e.id, e.qty, 1'b0);
          end else begin
            book[side][0].qty = e.qty - left;
            left = 0;
          end
        end
        post_fill(lob_pkg::ST_MKT_DONE, '0, '0, left, 1'b1);
      end
      default: ;  // undefined modes are dropped
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // result side: random backpressure, compare, watchdog
  always @(posedge clk) begin
    fill_t f;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (fills_due.size() == 0) begin
          report_mismatch("unexpected word", 32'(m_tuser), '0);
        end else begin
          f = fills_due.pop_front();
          if (m_tuser != f.status)
            report_mismatch("status", 32'(m_tuser), 32'(f.status));
          if (m_tdata[31:0] != f.agent)
            report_mismatch("agent", m_tdata[31:0], f.agent);
          if (m_tdata[63:32] != f.oid)
            report_mismatch("order id", m_tdata[63:32], f.oid);
          if (m_tdata[79:64] != f.units)
            report_mismatch("units", 32'(m_tdata[79:64]), 32'(f.units));
          if (m_tdata[95:80] != f.bid)
            report_mismatch("best bid", 32'(m_tdata[95:80]), 32'(f.bid));
          if (m_tdata[111:96] != f.ask)
            report_mismatch("best ask", 32'(m_tdata[111:96]), 32'(f.ask));
          if (m_tlast != f.last)
            report_mismatch("tlast", 32'(m_tlast), 32'(f.last));
        end
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
    m_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // drive one request word, wait for acceptance, then maybe idle
  task automatic send_order(logic [2:0] mode, logic [15:0] price, logic [15:0] qty,
                            logic [31:0] ag, logic [31:0] id);
    s_tuser <= mode;
    s_tdata <= {id, ag, qty, price};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    book_request(mode, price, qty, ag, id);
    if ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  order_row_t orders [] = '{
    '{lob_pkg::MODE_MKT_BUY,  16'd0, 16'd100, 32'd7, 32'd1,
      1, lob_pkg::ST_MKT_DONE, 16'd100},
    '{lob_pkg::MODE_MKT_SELL, 16'd0, 16'd0, 32'd0, 32'd0,
      1, lob_pkg::ST_MKT_DONE, 16'd0},
    '{lob_pkg::MODE_CAN_BID,  16'd0, 16'd0, 32'd0, 32'd5,
      1, lob_pkg::ST_NOT_FOUND, 16'd0},
    '{lob_pkg::MODE_CAN_ASK,  16'd0, 16'd0, 32'd0, 32'hFFFFFFFF,
      1, lob_pkg::ST_NOT_FOUND, 16'd0},
    '{lob_pkg::MODE_ADD_BID,  16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
      1, lob_pkg::ST_ADDED, 16'hFFFF},
    '{lob_pkg::MODE_ADD_BID,  16'd0, 16'd0, 32'd0, 32'd0,
      1, lob_pkg::ST_ADDED, 16'd0},
    '{lob_pkg::MODE_ADD_BID,  16'd500, 16'd10, 32'd11, 32'd20, 0, 0, 0},
    '{lob_pkg::MODE_ADD_BID,  16'd500, 16'd20, 32'd12, 32'd20, 0, 0, 0},
    '{lob_pkg::MODE_ADD_ASK,  16'd0, 16'd0, 32'd21, 32'd30,
      1, lob_pkg::ST_ADDED, 16'd0},
    '{lob_pkg::MODE_ADD_ASK,  16'hFFFF, 16'd40, 32'd22, 32'd31, 0, 0, 0},
    '{lob_pkg::MODE_ADD_ASK,  16'd600, 16'd30, 32'd23, 32'd32, 0, 0, 0},
    '{lob_pkg::MODE_ADD_ASK,  16'd600, 16'd5, 32'd24, 32'd33, 0, 0, 0},
    '{3'd6, 16'd1, 16'd1, 32'd1, 32'd1, 0, 0, 0},
    '{3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0},
    '{lob_pkg::MODE_CAN_BID,  16'd0, 16'd0, 32'd0, 32'd20, 0, 0, 0},
    '{lob_pkg::MODE_MKT_BUY,  16'd0, 16'd12, 32'd0, 32'd0, 0, 0, 0},
    '{lob_pkg::MODE_MKT_BUY,  16'd0, 16'd100, 32'd0, 32'd0, 0, 0, 0},
    '{lob_pkg::MODE_MKT_SELL, 16'd0, 16'd0, 32'd0, 32'd0, 0, 0, 0},
    '{lob_pkg::MODE_MKT_SELL, 16'd0, 16'd1, 32'd0, 32'd0, 0, 0, 0},
    '{lob_pkg::MODE_MKT_SELL, 16'd0, 16'hFFFF, 32'd0, 32'd0, 0, 0, 0},
    '{lob_pkg::MODE_MKT_BUY,  16'd0, 16'hFFFF, 32'd0, 32'd0, 0, 0, 0},
    '{lob_pkg::MODE_CAN_ASK,  16'd0, 16'd0, 32'd0, 32'd33, 0, 0, 0}
  };

  initial begin
    int n;
    int pick;
    logic [2:0]  mode;
    logic [15:0] price;
    logic [15:0] qty;
    logic [31:0] id;
    for (int s = 0; s < 2; s++) begin
      book_cnt[s] = 0;
      last_fill[s] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (orders[i]) begin
      send_order(orders[i].mode, orders[i].price, orders[i].qty, orders[i].agent,
                 orders[i].oid);
      if (orders[i].typed) begin
        if (fills_due[$].status != orders[i].exp_status)
          report_mismatch("table status", 32'(fills_due[$].status),
                          32'(orders[i].exp_status));
        if (fills_due[$].units != orders[i].exp_units)
          report_mismatch("table units", 32'(fills_due[$].units),
                          32'(orders[i].exp_units));
      end
    end

    // fill the bid side past its depth, then sweep it with one market sell
    for (int i = 0; i <= DEPTH; i++)
      send_order(lob_pkg::MODE_ADD_BID, 16'($urandom_range(100, 110)),
                 16'($urandom_range(0, 3)), $urandom, 32'(i));
    send_order(lob_pkg::MODE_MKT_SELL, '0, 16'hFFFF, '0, '0);

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 78 : 0;
      rcv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 26 : 0;
      n = 0;
      while (n < 132) begin
        pick = $urandom_range(99);
        if (pick < 30) mode = lob_pkg::MODE_ADD_BID;
        else if (pick < 60) mode = lob_pkg::MODE_ADD_ASK;
        else if (pick < 68) mode = lob_pkg::MODE_CAN_BID;
        else if (pick < 76) mode = lob_pkg::MODE_CAN_ASK;
        else if (pick < 86) mode = lob_pkg::MODE_MKT_BUY;
        else if (pick < 96) mode = lob_pkg::MODE_MKT_SELL;
        else mode = 3'($urandom_range(6, 7));
        price = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(980, 1020));
        pick = $urandom_range(19);
        if (pick == 0) qty = '0;
        else if (pick < 3) qty = 16'($urandom);
        else if (mode == lob_pkg::MODE_MKT_BUY || mode == lob_pkg::MODE_MKT_SELL)
          qty = 16'($urandom_range(1, 400));
        else qty = 16'($urandom_range(1, 200));
        id = ($urandom_range(9) < 7) ? $urandom_range(0, 31) : $urandom;
        send_order(mode, price, qty, $urandom, id);
        if (mode <= lob_pkg::MODE_MKT_SELL) n++;
      end
    end
    s_tvalid <= 0;

    while (fills_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && fills_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
